FILE: hdl/rwf_pkg.sv
// ----------------------------------------------------------------------------
// rwf_pkg
// Shared widths, codes, types and ring-address helper for the replay filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rwf_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W      = ADDR_W + 1;

  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned NONCE_W    = 64;
  localparam int unsigned WINDOW_W   = 31;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned HELD_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd60;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW     = 2'd0,
    CFG_SIZE_LIMIT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_ADD   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_WALK,
    ST_ADD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [NONCE_W-1:0] nonce_high;
    logic [NONCE_W-1:0] nonce_middle;
    logic [NONCE_W-1:0] nonce_low;
  } entry_t;

  typedef struct packed {
    logic expired;
    logic match;
  } cmp_res_t;

  // physical slot of a logical position relative to the ring head
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0]  base,
                                                  input logic [COUNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rwf_channels.sv
// ----------------------------------------------------------------------------
// rwf channels
// Valid/ready channel interfaces for requests, responses and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rwf_req_if;
  import rwf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [STAMP_W-1:0]   stamp;
  logic [STAMP_W-1:0]   current_time;
  logic [NONCE_W-1:0]   nonce_high;
  logic [NONCE_W-1:0]   nonce_middle;
  logic [NONCE_W-1:0]   nonce_low;

  modport source (output valid, operation, stamp, current_time, nonce_high,
                  nonce_middle, nonce_low, input ready);
  modport sink   (input valid, operation, stamp, current_time, nonce_high,
                  nonce_middle, nonce_low, output ready);
endinterface

interface rwf_rsp_if;
  import rwf_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [HELD_W-1:0] entries_held;

  modport source (output valid, accepted, entries_held, input ready);
  modport sink   (input valid, accepted, entries_held, output ready);
endinterface

interface rwf_cfg_if;
  import rwf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rwf_ram.sv
// ----------------------------------------------------------------------------
// rwf_ram
// Generic one-write one-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/rwf_cmp_unit.sv
// ----------------------------------------------------------------------------
// rwf_cmp_unit
// Shared entry compare: expiry against current time and exact key match.
// ----------------------------------------------------------------------------
`default_nettype none

module rwf_cmp_unit (
  input  rwf_pkg::entry_t                    entry_i,
  input  rwf_pkg::entry_t                    key_i,
  input  logic [rwf_pkg::STAMP_W-1:0]        now_i,
  input  logic [rwf_pkg::WINDOW_W-1:0]       window_i,
  output rwf_pkg::cmp_res_t                  res_o
);
  import rwf_pkg::*;

  localparam int unsigned EXP_W = STAMP_W + 1;

  logic [EXP_W-1:0] expiry;

  // one extra bit so stamp + window never wraps
  assign expiry        = EXP_W'(entry_i.stamp) + EXP_W'(window_i);
  assign res_o.expired = expiry < EXP_W'(now_i);
  assign res_o.match   = (entry_i == key_i);

endmodule

`default_nettype wire

FILE: hdl/replay_window_filter_core.sv
// ----------------------------------------------------------------------------
// replay_window_filter_core
// Anti-replay filter over (timestamp, nonce) entries kept in a ring memory.
// ----------------------------------------------------------------------------
// Add: ST_IDLE takes the request, ST_ADD writes the entry, ST_FINISH loads the result.
// Check refused as stale: ST_IDLE, ST_SCREEN, then ST_FINISH loads the result.
// Check with n stored entries: ST_IDLE, ST_SCREEN, ST_WALK over them, ST_FINISH;
//   the walk reads one entry per cycle through the single memory read port.
// ST_FINISH waits for a free response slot; then ST_IDLE takes the next request.
// Reset: entry count zero, window 60, size limit 64; no memory clearing pass.
`default_nettype none

module replay_window_filter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwf_req_if.sink    req_i,
  rwf_rsp_if.source  rsp_o,
  rwf_cfg_if.sink    cfg_i
);
  import rwf_pkg::*;

  state_e                state_q, state_d;

  logic [WINDOW_W-1:0]   window_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic [ADDR_W-1:0]     head_q;
  logic [COUNT_W-1:0]    count_q;
  logic [COUNT_W-1:0]    rd_q;
  logic [COUNT_W-1:0]    wr_q;
  logic                  pend_q;
  logic                  hit_q;
  logic                  rsp_valid_q;

  op_e                   op_q;
  entry_t                key_q;
  logic [STAMP_W-1:0]    now_q;
  logic                  acc_q;
  logic                  rsp_acc_q;
  logic [HELD_W-1:0]     rsp_held_q;

  logic                  req_take;
  logic                  rsp_free;
  logic                  rd_issue;
  logic                  walk_done;
  logic                  wr_keep;
  logic                  stale;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  entry_t                ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  entry_t                ram_rdata;
  cmp_res_t              cmp_res;

  logic [STAMP_W:0]      fwd_diff;
  logic [STAMP_W-1:0]    mag;

  logic                  full;
  logic [ADDR_W-1:0]     head1;
  logic [COUNT_W-1:0]    c1;
  logic [COUNT_W-1:0]    c2;
  logic [COUNT_W-1:0]    lim;
  logic                  over;
  logic [ADDR_W-1:0]     add_waddr;
  logic [ADDR_W-1:0]     head_add;
  logic [COUNT_W-1:0]    count_add;

  // --------------------------------------------------------------------------
  // shared memory and compare unit
  // --------------------------------------------------------------------------
  rwf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_issue),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rwf_cmp_unit u_cmp (
    .entry_i (ram_rdata),
    .key_i   (key_q),
    .now_i   (now_q),
    .window_i(window_q),
    .res_o   (cmp_res)
  );

  // --------------------------------------------------------------------------
  // datapath control
  // --------------------------------------------------------------------------
  assign req_take  = req_i.valid && (state_q == ST_IDLE);
  assign rsp_free  = !rsp_valid_q || rsp_o.ready;

  assign rd_issue  = (state_q == ST_WALK) && (rd_q < count_q);
  assign walk_done = (state_q == ST_WALK) && !rd_issue && !pend_q;
  // after a hit every remaining entry is moved down unchanged
  assign wr_keep   = pend_q && (hit_q || !cmp_res.expired);

  assign ram_raddr = ring_addr(head_q, rd_q);

  always_comb begin
    fwd_diff = {1'b0, now_q} - {1'b0, key_q.stamp};
    if (fwd_diff[STAMP_W]) begin
      mag = key_q.stamp - now_q;
    end else begin
      mag = fwd_diff[STAMP_W-1:0];
    end
    stale = mag > STAMP_W'(window_q);
  end

  always_comb begin
    full  = count_q >= COUNT_W'(DEPTH);
    head1 = full ? ring_addr(head_q, COUNT_W'(1)) : head_q;
    c1    = full ? COUNT_W'(DEPTH - 1) : count_q;
    add_waddr = ring_addr(head1, c1);
    c2    = c1 + COUNT_W'(1);
    if (32'(limit_q) > DEPTH) begin
      lim = COUNT_W'(DEPTH);
    end else begin
      lim = COUNT_W'(limit_q);
    end
    over = c2 > lim;
    if (over) begin
      head_add  = ring_addr(head1, c2 - lim);
      count_add = lim;
    end else begin
      head_add  = head1;
      count_add = c2;
    end
  end

  always_comb begin
    if (state_q == ST_ADD) begin
      ram_we    = 1'b1;
      ram_waddr = add_waddr;
      ram_wdata = key_q;
    end else begin
      ram_we    = wr_keep;
      ram_waddr = ring_addr(head_q, wr_q);
      ram_wdata = ram_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = (op_e'(req_i.operation) == OP_ADD) ? ST_ADD : ST_SCREEN;
        end
      end
      ST_SCREEN: begin
        state_d = stale ? ST_FINISH : ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_ADD: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_i.ready        = (state_q == ST_IDLE);
    rsp_o.valid        = rsp_valid_q;
    rsp_o.accepted     = rsp_acc_q;
    rsp_o.entries_held = rsp_held_q;
    cfg_i.ready        = 1'b1;
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      limit_q     <= LIMIT_RESET;
      head_q      <= '0;
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_WINDOW:     window_q <= cfg_i.data[WINDOW_W-1:0];
          CFG_SIZE_LIMIT: limit_q  <= cfg_i.data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end

      if (req_take) begin
        rd_q   <= '0;
        wr_q   <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end

      if (state_q == ST_WALK) begin
        pend_q <= rd_issue;
        if (rd_issue) begin
          rd_q <= rd_q + COUNT_W'(1);
        end
        if (pend_q) begin
          hit_q <= hit_q || (!cmp_res.expired && cmp_res.match);
        end
        if (wr_keep) begin
          wr_q <= wr_q + COUNT_W'(1);
        end
        if (walk_done) begin
          count_q <= wr_q;
        end
      end

      if (state_q == ST_ADD) begin
        head_q  <= head_add;
        count_q <= count_add;
      end

      if ((state_q == ST_FINISH) && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      op_q               <= op_e'(req_i.operation);
      key_q.stamp        <= req_i.stamp;
      key_q.nonce_high   <= req_i.nonce_high;
      key_q.nonce_middle <= req_i.nonce_middle;
      key_q.nonce_low    <= req_i.nonce_low;
      now_q              <= req_i.current_time;
    end

    if ((state_q == ST_SCREEN) && stale) begin
      acc_q <= 1'b0;
    end else if (walk_done) begin
      acc_q <= !hit_q;
    end else if ((state_q == ST_ADD) && (op_q == OP_ADD)) begin
      acc_q <= 1'b1;
    end

    if ((state_q == ST_FINISH) && rsp_free) begin
      rsp_acc_q  <= acc_q;
      rsp_held_q <= HELD_W'(count_q);
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_replay_window_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_replay_window_filter_core
// Self-checking bench for the replay filter: a directed table of checks and
// adds, then randomized phases under several window and size-limit settings,
// each response compared against its table entry or an in-bench model of the entry store.
// ----------------------------------------------------------------------------

module tb_replay_window_filter_core;
  import rwf_pkg::*;

  localparam int          LIMIT_CYCLES = 500000;
  localparam int          PRESSURE_AT  = 230;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

  localparam logic [STAMP_W-1:0] MAX48 = {STAMP_W{1'b1}};
  localparam logic [NONCE_W-1:0] ONES  = {NONCE_W{1'b1}};
  localparam logic [NONCE_W-1:0] PAT   = 64'hA5A5_5A5A_C3C3_3C3C;
  localparam logic [NONCE_W-1:0] ALT   = 64'h5A5A_A5A5_0FF0_F00F;

  typedef struct packed {
    logic              acc;
    logic [HELD_W-1:0] held;
  } verdict_t;

  typedef struct packed {
    op_e                op;
    logic [STAMP_W-1:0] now;
    entry_t             e;
  } packet_t;

  typedef struct packed {
    packet_t  p;
    bit       typed;
    verdict_t v;
  } vector_t;

  logic clk;
  logic rst_n;

  rwf_req_if req_if ();
  rwf_rsp_if rsp_if ();
  rwf_cfg_if cfg_if ();

  replay_window_filter_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // model of the filter state
  entry_t              stored[$];
  logic [WINDOW_W-1:0] win_cfg = WINDOW_RESET;
  logic [LIMIT_W-1:0]  lim_cfg = LIMIT_RESET;

  verdict_t            pending[$];
  vector_t             vectors[$];
  entry_t              recent[$];
  logic [STAMP_W-1:0]  clock_s;
  bit                  calm = 1'b0;
  int                  failures = 0;
  int                  results_seen = 0;
  int                  cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [STAMP_W-1:0] rand48();
    return STAMP_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [NONCE_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // expected response, updating the modeled store
  function automatic verdict_t screen_packet(packet_t p);
    verdict_t           v;
    logic [STAMP_W:0]   skew;
    logic [STAMP_W+1:0] reach;
    entry_t             kept[$];
    bit                 hit;
    int                 lim;
    v.acc = 1'b1;
    if (p.op == OP_CHECK) begin
      if (p.now >= p.e.stamp) skew = p.now - p.e.stamp;
      else skew = p.e.stamp - p.now;
      if (skew > win_cfg) begin
        v.acc = 1'b0;
      end else begin
        hit = 1'b0;
        foreach (stored[i]) begin
          reach = stored[i].stamp + win_cfg;
          // once matched, the rest of the store is left as it is
          if (hit || reach >= p.now) begin
            if (!hit && stored[i] == p.e) hit = 1'b1;
            kept.push_back(stored[i]);
          end
        end
        stored = kept;
        v.acc = !hit;
      end
    end else begin
      lim = (lim_cfg > DEPTH) ? DEPTH : int'(lim_cfg);
      if (stored.size() >= DEPTH) void'(stored.pop_front());
      stored.push_back(p.e);
      while (stored.size() > lim) void'(stored.pop_front());
    end
    v.held = HELD_W'(stored.size());
    return v;
  endfunction

  task automatic send_packet(input packet_t p, input bit typed, input verdict_t given);
    verdict_t v;
    int       gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.operation    <= p.op;
    req_if.stamp        <= p.e.stamp;
    req_if.current_time <= p.now;
    req_if.nonce_high   <= p.e.nonce_high;
    req_if.nonce_middle <= p.e.nonce_middle;
    req_if.nonce_low    <= p.e.nonce_low;
    req_if.valid        <= 1'b1;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    v = screen_packet(p);
    pending.push_back(typed ? given : v);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    if (idx == CFG_WINDOW) win_cfg = data[WINDOW_W-1:0];
    else if (idx == CFG_SIZE_LIMIT) lim_cfg = data[LIMIT_W-1:0];
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] win_data,
                           input logic [CFG_DATA_W-1:0] lim_data, input bit poke_unused);
    drain();
    set_reg(CFG_WINDOW, win_data);
    set_reg(CFG_SIZE_LIMIT, lim_data);
    if (poke_unused) set_reg(CFG_UNUSED, $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  task automatic row(input op_e op, input logic [STAMP_W-1:0] stamp,
                     input logic [STAMP_W-1:0] now, input logic [NONCE_W-1:0] nh,
                     input logic [NONCE_W-1:0] nm, input logic [NONCE_W-1:0] nl,
                     input bit typed, input logic acc, input int held);
    vector_t r;
    r.p.op    = op;
    r.p.now   = now;
    r.p.e     = '{stamp: stamp, nonce_high: nh, nonce_middle: nm, nonce_low: nl};
    r.typed   = typed;
    r.v.acc   = acc;
    r.v.held  = HELD_W'(held);
    vectors.push_back(r);
  endtask

  task automatic random_phase(input int count, input logic [STAMP_W-1:0] start);
    packet_t            p;
    logic [STAMP_W-1:0] off;
    logic [STAMP_W-1:0] far;
    int                 span;
    int                 kind;
    clock_s = start;
    span = (win_cfg > 200) ? 200 : int'(win_cfg);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      p.op = OP_CHECK;
      p.now = clock_s;
      p.e = '{stamp: rand48(), nonce_high: rand64(), nonce_middle: rand64(),
              nonce_low: rand64()};
      off = STAMP_W'($urandom_range(0, span));
      if (kind < 35) begin
        p.op = OP_ADD;
        p.now = rand48();
        p.e.stamp = $urandom_range(0, 1) ? clock_s - off : clock_s + off;
      end else if (kind < 55 && recent.size() != 0) begin
        // replay of a recent add, sometimes with one bit off
        p.e = recent[$urandom_range(0, recent.size() - 1)];
        if ($urandom_range(0, 3) == 0) p.e[$urandom_range(0, $bits(entry_t) - 1)] ^= 1'b1;
      end else if (kind < 80) begin
        p.e.stamp = $urandom_range(0, 1) ? clock_s - off : clock_s + off;
      end else if (kind < 90) begin
        far = STAMP_W'(win_cfg) + 1 + STAMP_W'($urandom_range(0, 50));
        p.e.stamp = $urandom_range(0, 1) ? clock_s - far : clock_s + far;
      end else begin
        p.op = op_e'($urandom_range(0, 1));
        p.now = rand48();
      end
      if (p.op == OP_ADD) begin
        recent.push_back(p.e);
        if (recent.size() > 24) void'(recent.pop_front());
      end
      send_packet(p, 1'b0, '0);
      clock_s += STAMP_W'($urandom_range(0, span / 6 + 1));
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;
  endtask

  // response side: random stalls, one long hold-off, compare each transaction
  initial begin : rsp_side
    int       gap;
    verdict_t want;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 8);
      if (results_seen == PRESSURE_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      results_seen++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected response: accepted=%0b held=%0d",
                   rsp_if.accepted, rsp_if.entries_held);
      end else begin
        want = pending.pop_front();
        if (rsp_if.accepted !== want.acc || rsp_if.entries_held !== want.held) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("response %0d mismatch: accepted exp %0b got %0b, held exp %0d got %0d",
                     results_seen, want.acc, rsp_if.accepted, want.held,
                     rsp_if.entries_held);
        end
      end
    end
  end

  initial begin : req_side
    clk                 = 1'b0;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_CHECK;
    req_if.stamp        = '0;
    req_if.current_time = '0;
    req_if.nonce_high   = '0;
    req_if.nonce_middle = '0;
    req_if.nonce_low    = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_WINDOW;
    cfg_if.data         = '0;

    // reset window 60, size limit 64
    row(OP_CHECK, 48'd0, 48'd0, 64'd0, 64'd0, 64'd0, 1, 1'b1, 0);
    row(OP_CHECK, 48'd0, 48'd61, 64'd0, 64'd0, 64'd0, 1, 1'b0, 0);
    row(OP_CHECK, MAX48, MAX48 - 48'd60, ONES, ONES, ONES, 1, 1'b1, 0);
    row(OP_CHECK, 48'd0, MAX48, 64'd0, 64'd0, 64'd0, 1, 1'b0, 0);
    row(OP_ADD, 48'd1000, 48'd0, ONES, ONES, ONES, 1, 1'b1, 1);
    row(OP_CHECK, 48'd1000, 48'd1000, ONES, ONES, ONES, 1, 1'b0, 1);
    // near misses on each part of the key
    row(OP_CHECK, 48'd1000, 48'd1000, ONES, ONES, ONES ^ 64'd1, 1, 1'b1, 1);
    row(OP_CHECK, 48'd1000, 48'd1000, ONES ^ (64'd1 << 63), ONES, ONES, 1, 1'b1, 1);
    row(OP_CHECK, 48'd1000, 48'd1000, ONES, ONES ^ (64'd1 << 31), ONES, 1, 1'b1, 1);
    row(OP_CHECK, 48'd1001, 48'd1000, ONES, ONES, ONES, 1, 1'b1, 1);
    row(OP_ADD, 48'd1010, MAX48, 64'd0, 64'd0, 64'd0, 1, 1'b1, 2);
    row(OP_ADD, 48'd1020, 48'd0, PAT, ~PAT, PAT, 1, 1'b1, 3);
    // stale check leaves the store untouched
    row(OP_CHECK, 48'd2000, 48'd1000, PAT, ~PAT, PAT, 1, 1'b0, 3);
    // purge two expired entries, then hit
    row(OP_CHECK, 48'd1020, 48'd1075, PAT, ~PAT, PAT, 0, 1'b0, 0);
    row(OP_ADD, 48'd1100, 48'd0, ONES, ONES, ONES, 0, 1'b0, 0);
    row(OP_ADD, MAX48, 48'd0, ALT, ~ALT, ALT, 0, 1'b0, 0);
    row(OP_CHECK, 48'd1020, 48'd1060, PAT, ~PAT, PAT, 0, 1'b0, 0);
    row(OP_CHECK, 48'd1100, 48'd1100, 64'd0, 64'd0, 64'd0, 0, 1'b0, 0);
    row(OP_ADD, 48'd0, 48'd0, 64'd0, 64'd0, 64'd0, 0, 1'b0, 0);
    // hit on the newest-but-one entry, the one after it must survive
    row(OP_CHECK, MAX48, MAX48, ALT, ~ALT, ALT, 0, 1'b0, 0);
    row(OP_CHECK, MAX48 - 48'd60, MAX48, 64'd0, 64'd0, 64'd0, 0, 1'b0, 0);
    row(OP_ADD, MAX48, MAX48, ONES, ONES, ONES, 0, 1'b0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (vectors[i]) send_packet(vectors[i].p, vectors[i].typed, vectors[i].v);
    req_if.valid <= 1'b0;

    configure(32'h8000_003C, 32'h0000_0040, 1'b0);
    random_phase(150, rand48());
    configure(32'h0000_0000, 32'h0000_0000, 1'b0);
    random_phase(40, rand48());
    // widest window, size limit beyond the store depth
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    random_phase(150, MAX48 - 48'd100000);
    configure(32'h0000_0005, 32'h0000_0081, 1'b0);
    random_phase(60, STAMP_W'($urandom_range(0, 20)));
    configure(32'd1000, 32'd8, 1'b1);
    random_phase(150, rand48());
    configure(32'd20, 32'hFFFF_FFC0, 1'b0);
    random_phase(180, rand48());

    drain();
    repeat (80) @(posedge clk);
    if (failures == 0 && pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rwf_pkg.sv
hdl/rwf_channels.sv
hdl/rwf_ram.sv
hdl/rwf_cmp_unit.sv
hdl/replay_window_filter_core.sv
bench/tb_replay_window_filter_core.sv
